>>> hw/rtl/bsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg - shared types and constants of the byte stack machine
// Opcodes, status and print codes, cell commands and the control structs
// that pass between the decoder, the cells and the top level.
// ----------------------------------------------------------------------------
package bsm_pkg;

   // instruction opcodes
   localparam logic [7:0] OP_PUSH  = 8'd1;
   localparam logic [7:0] OP_POP   = 8'd2;
   localparam logic [7:0] OP_SWAP  = 8'd3;
   localparam logic [7:0] OP_INPUT = 8'd4;
   localparam logic [7:0] OP_PNUM  = 8'd5;
   localparam logic [7:0] OP_PCHAR = 8'd6;
   localparam logic [7:0] OP_ADD   = 8'd7;
   localparam logic [7:0] OP_SUB   = 8'd8;
   localparam logic [7:0] OP_MUL   = 8'd9;

   // signed byte limits
   localparam logic signed [15:0] BYTE_MAX = 16'sd127;
   localparam logic signed [15:0] BYTE_MIN = -16'sd128;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_OVER  = 3'd2,
      ST_UNDER = 3'd3,
      ST_BADOP = 3'd4,
      ST_FULL  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_NUM  = 2'd1,
      KIND_CHAR = 2'd2
   } print_kind_type;

   // what every cell does with its entry
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP1,
      CELL_POP2,
      CELL_SWAP,
      CELL_COMBINE
   } cell_op_type;

   typedef enum logic [2:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_DEC2,
      CNT_CLEAR
   } count_op_type;

   typedef struct packed {
      logic is_top;
      logic is_second;
   } cell_role_type;

   typedef struct packed {
      logic empty;
      logic has_two;
      logic full;
   } stack_flags_type;

   typedef struct packed {
      cell_op_type  cell_op;
      logic [7:0]   load;
      count_op_type count_op;
   } stack_cmd_type;

   typedef struct packed {
      status_type     status;
      print_kind_type kind;
      logic [7:0]     value;
   } result_type;

endpackage
`default_nettype wire

>>> hw/rtl/bsm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_cell - one stack entry
// Holds one byte and takes its next value from itself, a neighbor or the load byte, as
// the broadcast cell command and the cell's place in the chain select.
// ----------------------------------------------------------------------------
module bsm_cell (
   input  wire                   clock,
   input  bsm_pkg::cell_role_type role,
   input  bsm_pkg::cell_op_type   op,
   input  wire [7:0]             above,
   input  wire [7:0]             down1,
   input  wire [7:0]             down2,
   output logic [7:0]            value
);

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (op)
         bsm_pkg::CELL_HOLD:    value_in = value_ff;
         bsm_pkg::CELL_PUSH:    value_in = above;
         bsm_pkg::CELL_POP1:    value_in = down1;
         bsm_pkg::CELL_POP2:    value_in = down2;
         bsm_pkg::CELL_SWAP: begin
            if (role.is_top) begin
               value_in = down1;
            end else if (role.is_second) begin
               value_in = above;
            end
         end
         // top takes the fresh result, the rest close the gap of one
         bsm_pkg::CELL_COMBINE: value_in = role.is_top ? above : down1;
         default:               value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bsm_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_alu - instruction decode and arithmetic
// Turns one instruction and the top two entries into a stack command and
// the result beat: status, print kind and printed value.
// ----------------------------------------------------------------------------
module bsm_alu (
   input  wire [7:0]               opcode,
   input  wire signed [7:0]        operand,
   input  wire [7:0]               top,
   input  wire [7:0]               second,
   input  bsm_pkg::stack_flags_type flags,
   output bsm_pkg::stack_cmd_type   cmd,
   output bsm_pkg::result_type      result
);

   logic signed [15:0] a_wide;
   logic signed [15:0] b_wide;
   logic signed [15:0] arith;

   assign a_wide = {{8{top[7]}}, top};
   assign b_wide = {{8{second[7]}}, second};

   always_comb begin
      case (opcode)
         bsm_pkg::OP_ADD: arith = a_wide + b_wide;
         bsm_pkg::OP_SUB: arith = a_wide - b_wide;
         default:         arith = a_wide * b_wide;
      endcase
   end

   always_comb begin
      cmd.cell_op   = bsm_pkg::CELL_HOLD;
      cmd.load      = operand;
      cmd.count_op  = bsm_pkg::CNT_HOLD;
      result.status = bsm_pkg::ST_OK;
      result.kind   = bsm_pkg::KIND_NONE;
      result.value  = 8'd0;
      unique case (opcode)
         bsm_pkg::OP_PUSH, bsm_pkg::OP_INPUT: begin
            if (flags.full) begin
               result.status = bsm_pkg::ST_FULL;
            end else begin
               cmd.cell_op  = bsm_pkg::CELL_PUSH;
               cmd.count_op = bsm_pkg::CNT_INC;
            end
         end
         bsm_pkg::OP_POP: begin
            if (flags.empty) begin
               result.status = bsm_pkg::ST_EMPTY;
            end else begin
               cmd.cell_op  = bsm_pkg::CELL_POP1;
               cmd.count_op = bsm_pkg::CNT_DEC;
            end
         end
         bsm_pkg::OP_SWAP: begin
            if (!flags.has_two) begin
               // drop the lone entry, if any
               result.status = bsm_pkg::ST_EMPTY;
               cmd.count_op  = bsm_pkg::CNT_CLEAR;
            end else begin
               cmd.cell_op = bsm_pkg::CELL_SWAP;
            end
         end
         bsm_pkg::OP_PNUM: begin
            if (flags.empty) begin
               result.status = bsm_pkg::ST_EMPTY;
            end else begin
               result.kind  = bsm_pkg::KIND_NUM;
               result.value = top;
            end
         end
         bsm_pkg::OP_PCHAR: begin
            result.kind  = bsm_pkg::KIND_CHAR;
            result.value = operand;
         end
         bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_MUL: begin
            if (!flags.has_two) begin
               result.status = bsm_pkg::ST_EMPTY;
               cmd.count_op  = bsm_pkg::CNT_CLEAR;
            end else if (arith > bsm_pkg::BYTE_MAX) begin
               result.status = bsm_pkg::ST_OVER;
               cmd.cell_op   = bsm_pkg::CELL_POP2;
               cmd.count_op  = bsm_pkg::CNT_DEC2;
            end else if (arith < bsm_pkg::BYTE_MIN) begin
               result.status = bsm_pkg::ST_UNDER;
               cmd.cell_op   = bsm_pkg::CELL_POP2;
               cmd.count_op  = bsm_pkg::CNT_DEC2;
            end else begin
               cmd.cell_op  = bsm_pkg::CELL_COMBINE;
               cmd.load     = arith[7:0];
               cmd.count_op = bsm_pkg::CNT_DEC;
            end
         end
         default: begin
            result.status = bsm_pkg::ST_BADOP;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/byte_stack_machine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stack_machine - 8-bit stack machine on a chain of stack cells
// Executes one instruction per request beat on a stack of signed bytes and
// returns one response beat per instruction.
// ----------------------------------------------------------------------------
// For each instruction the request beat is decoded, the top two cells feed
// the adder/subtractor/8x8 multiplier, and the whole cell chain shifts,
// swaps or holds at the edge that accepts the beat.
// The response appears in the cycle after, in an output register, and the next
// request is taken in that same cycle, so the block sustains one
// instruction per clock while rsp_stall is low. req_stall rises only while
// a finished response sits unread under rsp_stall. The stack is DEPTH
// cells deep with cell 0 as the top; entries above the fill count hold
// stale data and are never shown. Status codes: ok, stack empty, overflow,
// underflow, bad opcode, stack full. print_value is zero unless a number or
// a character is printed.
// ----------------------------------------------------------------------------
module byte_stack_machine #(
   parameter int DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire [7:0]         req_opcode,
   input  wire signed [7:0]  req_operand,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [1:0]        rsp_print_kind,
   output logic signed [7:0] rsp_print_value
);

   localparam int CW = $clog2(DEPTH + 1);

   // fill count
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   bsm_pkg::result_type      rsp_ff;

   logic                     accept;
   logic [7:0]               cell_q [DEPTH];
   bsm_pkg::stack_flags_type flags;
   bsm_pkg::stack_cmd_type   cmd;
   bsm_pkg::result_type      result;
   bsm_pkg::cell_op_type     cell_op;

   // hold the request while a response waits unread
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign flags.empty   = (count_ff == '0);
   assign flags.has_two = (count_ff >= CW'(2));
   assign flags.full    = (count_ff == CW'(DEPTH));

   bsm_alu u_alu (
      .opcode  (req_opcode),
      .operand (req_operand),
      .top     (cell_q[0]),
      .second  (cell_q[1]),
      .flags   (flags),
      .cmd     (cmd),
      .result  (result)
   );

   // cells move only on an accepted beat
   assign cell_op = accept ? cmd.cell_op : bsm_pkg::CELL_HOLD;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0]             above;
      logic [7:0]             down1;
      logic [7:0]             down2;
      bsm_pkg::cell_role_type role;

      assign role.is_top    = (i == 0);
      assign role.is_second = (i == 1);

      if (i == 0) begin : g_top
         assign above = cmd.load;
      end else begin : g_mid
         assign above = cell_q[i-1];
      end

      // past the bottom the stack reads as don't-care; feed zero
      if (i + 1 < DEPTH) begin : g_d1
         assign down1 = cell_q[i+1];
      end else begin : g_d1_end
         assign down1 = 8'd0;
      end

      if (i + 2 < DEPTH) begin : g_d2
         assign down2 = cell_q[i+2];
      end else begin : g_d2_end
         assign down2 = 8'd0;
      end

      bsm_cell u_cell (
         .clock (clock),
         .role  (role),
         .op    (cell_op),
         .above (above),
         .down1 (down1),
         .down2 (down2),
         .value (cell_q[i])
      );
   end

   // advance the fill count
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (cmd.count_op)
            bsm_pkg::CNT_HOLD:  count_in = count_ff;
            bsm_pkg::CNT_INC:   count_in = count_ff + CW'(1);
            bsm_pkg::CNT_DEC:   count_in = count_ff - CW'(1);
            bsm_pkg::CNT_DEC2:  count_in = count_ff - CW'(2);
            bsm_pkg::CNT_CLEAR: count_in = '0;
            default:            count_in = count_ff;
         endcase
      end
   end

   // response valid: set on accept, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_print_kind  = rsp_ff.kind;
   assign rsp_print_value = rsp_ff.value;

   // the fill count never runs past the chain
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count beyond stack depth");

   // a successful push grows the stack by one and lands the operand on top
   a_push_lands : assert property (@(posedge clock) disable iff (reset)
      accept && cmd.cell_op == bsm_pkg::CELL_PUSH
      |=> count_ff == $past(count_ff) + CW'(1) && cell_q[0] == $past(req_operand))
      else $error("push did not land on top");

   // a printed number is the top entry of the accepting cycle
   a_print_top : assert property (@(posedge clock) disable iff (reset)
      accept && result.kind == bsm_pkg::KIND_NUM
      |=> rsp_print_value == $past(cell_q[0]))
      else $error("printed number differs from top entry");

   // nothing printed means a zero value
   a_print_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_print_kind == bsm_pkg::KIND_NONE |-> rsp_print_value == 8'sd0)
      else $error("print value set with nothing printed");

   // a stall-free response drains in the next cycle when no new beat comes
   a_drain : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !req_valid |=> !rsp_valid_ff)
      else $error("response not dropped after it was taken");

endmodule
`default_nettype wire
